>>> rtl/tsppo_pkg.sv
// Shared constants, types and helpers for the transport packet pattern overwrite block.
// Used by tsppo_pid_table and ts_payload_pattern_overwrite; depends on nothing.
package tsppo_pkg;

    localparam int PACKET_BYTES      = 188;
    localparam int PAYLOAD_MAX       = PACKET_BYTES - 4;
    localparam int PATTERN_DEPTH_DEF = 184;
    localparam int PID_COUNT         = 8192;
    localparam int PID_W             = $clog2(PID_COUNT);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // Item modes carried in the input tuser
    localparam logic [1:0] MODE_PACKET  = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_PID     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_PUSI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_OTHER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_PID_LIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATE         = 3'd4;

    typedef struct packed {
        logic             wr;
        logic             rd;
        logic [PID_W-1:0] addr;
        logic             wbit;
    } t_pid_req;

    // Saturate a header or start position at the packet end
    function automatic logic [7:0] cap_pkt(input logic [8:0] v);
        logic [7:0] r;
        if (v > 9'(PACKET_BYTES)) begin
            r = 8'(PACKET_BYTES);
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/tsppo_pid_table.sv
// PID selection bit table: 8192 x 1 synchronous memory with a clearing pass after reset.
// Depends on tsppo_pkg.
module tsppo_pid_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsppo_pkg::t_pid_req i_req,
    input  logic                i_use_list,
    input  logic                i_negate,
    output logic                o_pass,
    output logic                o_busy
);

    logic                          r_mem [tsppo_pkg::PID_COUNT];
    logic                          r_q;
    logic                          r_clearing;
    logic [tsppo_pkg::PID_W-1:0]   r_clr_addr;

    // Sweep every entry to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == tsppo_pkg::PID_W'(tsppo_pkg::PID_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wbit;
        end
        if (i_req.rd) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    assign o_pass = (i_use_list ? r_q : 1'b1) ^ i_negate;
    assign o_busy = r_clearing;

endmodule

>>> rtl/ts_payload_pattern_overwrite.sv
// Top level: transport packet parser with payload pattern overwrite.
// Depends on tsppo_pkg and tsppo_pid_table.
//
//  channel   | direction | fields (lowest bit first)
//  ----------+-----------+-------------------------------------------------------
//  s (in)    | sink      | tuser: mode[1:0]; tdata: data_byte[7:0],
//            |           |   start_of_packet[8], slot[21:9], bit_value[22], 0[23]
//  m (out)   | source    | tdata: out_byte[7:0]; tuser: replaced[0]; tlast: last
//  cfg       | write     | i_cfg_we, i_cfg_index, i_cfg_wdata
//
// One word is taken every cycle while input ready is high; a packet word passes
// through the read stage (synchronous PID table / pattern memory read) and
// then the output register. Input ready follows the output register: it
// drops while a finished word waits and the sink holds tready low, and
// after reset while the PID table clears all 8192 entries, during which
// no word is accepted; configuration writes are taken at all times.
module ts_payload_pattern_overwrite #(
    parameter int PATTERN_DEPTH = tsppo_pkg::PATTERN_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [tsppo_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // data_byte, start_of_packet, slot, bit_value
    input  logic [1:0]                           i_s_tuser,  // mode
    // output stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [tsppo_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // out_byte
    output logic                                 o_m_tuser,  // replaced
    output logic                                 o_m_tlast,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [tsppo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tsppo_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int PW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(PATTERN_DEPTH);

    // Configuration registers
    logic [7:0] r_cfg_len;
    logic [7:0] r_cfg_off_pusi;
    logic [7:0] r_cfg_off_other;
    logic       r_cfg_use_list;
    logic       r_cfg_negate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len       <= 8'd1;
            r_cfg_off_pusi  <= '0;
            r_cfg_off_other <= '0;
            r_cfg_use_list  <= 1'b0;
            r_cfg_negate    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsppo_pkg::CFG_PATTERN_LENGTH: r_cfg_len       <= i_cfg_wdata;
                tsppo_pkg::CFG_OFFSET_PUSI:    r_cfg_off_pusi  <= i_cfg_wdata;
                tsppo_pkg::CFG_OFFSET_OTHER:   r_cfg_off_other <= i_cfg_wdata;
                tsppo_pkg::CFG_USE_PID_LIST:   r_cfg_use_list  <= i_cfg_wdata[0];
                tsppo_pkg::CFG_NEGATE:         r_cfg_negate    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input field unpacking
    logic [1:0]                  s_mode;
    logic [7:0]                  s_byte;
    logic                        s_sop;
    logic [tsppo_pkg::PID_W-1:0] s_slot;
    logic                        s_bit;

    assign s_mode = i_s_tuser;
    assign s_byte = i_s_tdata[7:0];
    assign s_sop  = i_s_tdata[8];
    assign s_slot = i_s_tdata[21:9];
    assign s_bit  = i_s_tdata[22];

    // Parser state
    logic [7:0]    r_pos,     n_pos;
    logic [4:0]    r_pid_hi,  n_pid_hi;
    logic          r_pusi,    n_pusi;
    logic          r_payload, n_payload;
    logic          r_pidpass, n_pidpass;
    logic          r_adapt,   n_adapt;
    logic [7:0]    r_start,   n_start;
    logic [PW-1:0] r_pidx,    n_pidx;

    // Read stage and output register
    logic       r_b_valid;
    logic [7:0] r_b_byte;
    logic       r_b_rep;
    logic       r_b_last;
    logic       r_b_pidchk;
    logic       r_c_valid;
    logic [7:0] r_c_byte;
    logic       r_c_rep;
    logic       r_c_last;

    logic [7:0] r_pat_mem [PATTERN_DEPTH];
    logic [7:0] r_pat_q;

    logic                  advance;
    logic                  accept;
    logic                  pkt;
    logic                  pid_busy;
    logic                  pid_pass;
    tsppo_pkg::t_pid_req   pid_req;
    logic [7:0]            pos;
    logic [7:0]            offset;
    logic [7:0]            hdr;
    logic [8:0]            eff_len;
    logic [PW-1:0]         idx;
    logic [8:0]            idx_inc;
    logic                  rep;
    logic                  last;
    logic                  pat_wr;

    // Advance the read stage whenever the output register is free or drains
    assign advance    = !r_c_valid || i_m_tready;
    assign o_s_tready = advance && !pid_busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign pkt        = accept && (s_mode == tsppo_pkg::MODE_PACKET);
    assign pat_wr     = accept && (s_mode == tsppo_pkg::MODE_PATTERN)
                        && (s_slot < tsppo_pkg::PID_W'(PATTERN_DEPTH));

    // Pattern length: zero acts as one, clamp at the memory depth
    always_comb begin
        if (r_cfg_len == 8'd0) begin
            eff_len = 9'd1;
        end else if ({1'b0, r_cfg_len} > DEPTH9) begin
            eff_len = DEPTH9;
        end else begin
            eff_len = {1'b0, r_cfg_len};
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_pid_hi  = r_pid_hi;
        n_pusi    = r_pusi;
        n_payload = r_payload;
        n_pidpass = r_pidpass;
        n_adapt   = r_adapt;
        n_start   = r_start;
        n_pidx    = r_pidx;
        hdr       = 8'd0;
        idx       = '0;
        idx_inc   = 9'd0;
        rep       = 1'b0;
        last      = 1'b0;

        pid_req.wr   = accept && (s_mode == tsppo_pkg::MODE_PID);
        pid_req.rd   = 1'b0;
        pid_req.addr = s_slot;
        pid_req.wbit = s_bit;

        offset = r_pusi ? r_cfg_off_pusi : r_cfg_off_other;
        pos    = (s_sop || r_pos >= 8'(tsppo_pkg::PACKET_BYTES)) ? 8'd0 : r_pos;

        // PID lookup issued at byte 2 resolves one stage later
        if (r_b_valid && r_b_pidchk && advance) begin
            n_pidpass = pid_pass;
        end

        if (pkt) begin
            if (pos == 8'd0) begin
                n_pidpass = 1'b0;
                n_payload = 1'b0;
                n_adapt   = 1'b0;
                n_start   = 8'(tsppo_pkg::PACKET_BYTES);
                n_pidx    = '0;
            end else if (pos == 8'd1) begin
                n_pid_hi = s_byte[4:0];
                n_pusi   = s_byte[6];
            end else if (pos == 8'd2) begin
                pid_req.rd   = 1'b1;
                pid_req.addr = {r_pid_hi, s_byte};
            end else if (pos == 8'd3) begin
                n_payload = s_byte[4];
                n_adapt   = s_byte[5];
                if (s_byte[5]) begin
                    n_start = 8'(tsppo_pkg::PACKET_BYTES);
                end else begin
                    n_start = tsppo_pkg::cap_pkt(9'd4 + {1'b0, offset});
                end
            end else if (pos == 8'd4 && r_adapt) begin
                hdr     = tsppo_pkg::cap_pkt(9'd5 + {1'b0, s_byte});
                n_start = tsppo_pkg::cap_pkt({1'b0, hdr} + {1'b0, offset});
            end

            // Replace from the start position on; wrap the pattern index
            if (r_pidpass && r_payload && pos >= n_start) begin
                rep     = 1'b1;
                idx     = ({{(9-PW){1'b0}}, r_pidx} >= eff_len) ? '0 : r_pidx;
                idx_inc = {{(9-PW){1'b0}}, idx} + 9'd1;
                n_pidx  = (idx_inc >= eff_len) ? '0 : idx_inc[PW-1:0];
            end

            last  = (pos == 8'(tsppo_pkg::PACKET_BYTES - 1));
            n_pos = last ? 8'd0 : pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pid_hi  <= '0;
            r_pusi    <= 1'b0;
            r_payload <= 1'b0;
            r_pidpass <= 1'b0;
            r_adapt   <= 1'b0;
            r_start   <= '0;
            r_pidx    <= '0;
        end else begin
            r_pos     <= n_pos;
            r_pid_hi  <= n_pid_hi;
            r_pusi    <= n_pusi;
            r_payload <= n_payload;
            r_pidpass <= n_pidpass;
            r_adapt   <= n_adapt;
            r_start   <= n_start;
            r_pidx    <= n_pidx;
        end
    end

    // Pattern memory: write on load words, read only when a byte is replaced
    always_ff @(posedge i_clk) begin
        if (pat_wr) begin
            r_pat_mem[s_slot[PW-1:0]] <= s_byte;
        end
        if (rep) begin
            r_pat_q <= r_pat_mem[idx];
        end
    end

    tsppo_pid_table u_pid_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (pid_req),
        .i_use_list (r_cfg_use_list),
        .i_negate   (r_cfg_negate),
        .o_pass     (pid_pass),
        .o_busy     (pid_busy)
    );

    // Read stage, then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= pkt;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_byte   <= s_byte;
            r_b_rep    <= rep;
            r_b_last   <= last;
            r_b_pidchk <= pid_req.rd;
            r_c_byte   <= r_b_rep ? r_pat_q : r_b_byte;
            r_c_rep    <= r_b_rep;
            r_c_last   <= r_b_last;
        end
    end

    assign o_m_tvalid = r_c_valid;
    assign o_m_tdata  = r_c_byte;
    assign o_m_tuser  = r_c_rep;
    assign o_m_tlast  = r_c_last;

endmodule
